// File: sv/llkf_pkg.sv
// Shared types, constants and helper functions of the link login and keepalive controller.
package llkf_pkg;

  // Field widths.
  localparam int TIMER_BITS = 17;
  localparam int PERIOD_W   = 17;
  localparam int TICK_W     = 16;
  localparam int SALT_W     = 32;
  localparam int CFG_IDX_W  = 2;

  // Results per input item and the width of a result count.
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;

  // Timer arithmetic widths.
  localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
  localparam int SUM_W = ((CMP_W > TICK_W) ? CMP_W : TICK_W) + 1;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

  // Register reset values.
  localparam logic [PERIOD_W-1:0] RETRY_PERIOD_RST   = PERIOD_W'(10 * 1000);
  localparam logic [PERIOD_W-1:0] TIMEOUT_PERIOD_RST = PERIOD_W'(60 * 1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_ENABLED      = 2'd0,
    CFG_OPTIONS_PRESENT = 2'd1,
    CFG_RETRY_PERIOD    = 2'd2,
    CFG_TIMEOUT_PERIOD  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_STEP   = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_BEACON = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PKT_DATA     = 3'd0,
    PKT_NAK      = 3'd1,
    PKT_ACK      = 3'd2,
    PKT_MST_CLOSE = 3'd3,
    PKT_PONG     = 3'd4,
    PKT_BEACON   = 3'd5,
    PKT_UNKNOWN  = 3'd6
  } pkt_kind_e;

  typedef enum logic [2:0] {
    ST_CONNECT = 3'd0,
    ST_LOGIN   = 3'd1,
    ST_AUTH    = 3'd2,
    ST_CONFIG  = 3'd3,
    ST_OPTIONS = 3'd4,
    ST_RUNNING = 3'd5
  } link_state_e;

  typedef enum logic [2:0] {
    SND_NONE    = 3'd0,
    SND_LOGIN   = 3'd1,
    SND_AUTH    = 3'd2,
    SND_CONFIG  = 3'd3,
    SND_OPTIONS = 3'd4,
    SND_PING    = 3'd5,
    SND_NOTICE  = 3'd6
  } send_kind_e;

  typedef enum logic [1:0] {
    SOCK_NONE  = 2'd0,
    SOCK_OPEN  = 2'd1,
    SOCK_CLOSE = 2'd2
  } sock_act_e;

  // Input item payload.
  typedef struct packed {
    logic [1:0]        mode;
    logic [TICK_W-1:0] tick_ms;
    logic              packet_present;
    logic              from_master;
    logic [2:0]        packet_kind;
    logic [SALT_W-1:0] salt_word;
    logic              read_failed;
    logic              socket_open_ok;
    logic              send_ok;
  } in_item_t;

  // Result item payload.
  typedef struct packed {
    logic [2:0]        send_kind;
    logic [1:0]        socket_action;
    logic              enqueue_data;
    logic              beacon_flag;
    logic [2:0]        link_state;
    logic [SALT_W-1:0] auth_salt;
    logic              last;
  } out_item_t;

  // Configuration registers.
  typedef struct packed {
    logic                rx_enabled;
    logic                options_present;
    logic [PERIOD_W-1:0] retry_period;
    logic [PERIOD_W-1:0] timeout_period;
  } cfg_t;

  // Link controller state.
  typedef struct packed {
    link_state_e           link;
    logic [TIMER_BITS-1:0] retry_el;
    logic                  retry_run;
    logic [TIMER_BITS-1:0] to_el;
    logic                  to_run;
    logic                  beacon;
    logic [SALT_W-1:0]     salt;
  } state_t;

  // Ordered list of send and socket actions of one item.
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    logic [MAX_RES-1:0][2:0]   snd;
    logic [MAX_RES-1:0][1:0]   sck;
  } res_list_t;

  // Working context while one item is processed.
  typedef struct packed {
    state_t    st;
    res_list_t lst;
  } ctx_t;

  // Complete result set of one item, handed to the result buffer.
  typedef struct packed {
    res_list_t         lst;
    logic              enq;
    logic              bflag;
    logic [2:0]        link;
    logic [SALT_W-1:0] salt;
  } res_set_t;

  // Advance a running timer with a nonzero period by the step time, saturating at the top value.
  function automatic logic [TIMER_BITS-1:0] timer_clock(
    input logic [TIMER_BITS-1:0] e,
    input logic                  run,
    input logic [PERIOD_W-1:0]   period,
    input logic [TICK_W-1:0]     ms
  );
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(e) + SUM_W'(ms);
    timer_clock = e;
    if (run && (period != '0)) begin
      timer_clock = (sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX : sum[TIMER_BITS-1:0];
    end
  endfunction

  // A timer has expired when it runs, has a period and has reached it.
  function automatic logic timer_expired(
    input logic [TIMER_BITS-1:0] e,
    input logic                  run,
    input logic [PERIOD_W-1:0]   period
  );
    timer_expired = run && (period != '0) && (CMP_W'(e) >= CMP_W'(period));
  endfunction

  // Append a new entry if there is room.
  function automatic res_list_t new_res(
    input res_list_t  l,
    input logic [2:0] s,
    input logic [1:0] a
  );
    new_res = l;
    if (l.cnt < CNT_W'(MAX_RES)) begin
      new_res.snd[l.cnt] = s;
      new_res.sck[l.cnt] = a;
      new_res.cnt        = l.cnt + CNT_W'(1);
    end
  endfunction

  // A packet fills an empty entry or opens a new one.
  function automatic res_list_t push_send(
    input res_list_t  l,
    input logic [2:0] k
  );
    logic [CNT_W-1:0] lix;
    lix = l.cnt - CNT_W'(1);
    if ((l.cnt != '0) && (l.snd[lix] == SND_NONE) && (l.sck[lix] == SOCK_NONE)) begin
      push_send          = l;
      push_send.snd[lix] = k;
    end else begin
      push_send = new_res(l, k, SOCK_NONE);
    end
  endfunction

  // A socket action follows the last packet; a repeated close is merged.
  function automatic res_list_t push_sock(
    input res_list_t  l,
    input logic [1:0] a
  );
    logic [CNT_W-1:0] lix;
    lix       = l.cnt - CNT_W'(1);
    push_sock = l;
    if ((l.cnt != '0) && (l.sck[lix] == SOCK_NONE)) begin
      push_sock.sck[lix] = a;
    end else if ((l.cnt != '0) && (a == SOCK_CLOSE) && (l.sck[lix] == SOCK_CLOSE)) begin
      push_sock = l;
    end else begin
      push_sock = new_res(l, SND_NONE, a);
    end
  endfunction

  // Back to connect: watchdog stopped, retry timer restarted.
  function automatic ctx_t link_open(input ctx_t c);
    link_open              = c;
    link_open.st.link      = ST_CONNECT;
    link_open.st.to_el     = '0;
    link_open.st.to_run    = 1'b0;
    link_open.st.retry_el  = TIMER_ONE;
    link_open.st.retry_run = 1'b1;
  endfunction

  // Send a packet; a failed write closes the socket and reconnects.
  function automatic ctx_t send_pkt(
    input ctx_t       c,
    input logic [2:0] k,
    input logic       ok
  );
    send_pkt     = c;
    send_pkt.lst = push_send(c.lst, k);
    if (!ok) begin
      send_pkt.lst = push_sock(send_pkt.lst, SOCK_CLOSE);
      send_pkt     = link_open(send_pkt);
    end
  endfunction

  // Close the link: notice when running, close the socket, stop both timers.
  function automatic ctx_t link_close(
    input ctx_t c,
    input logic ok
  );
    link_close = c;
    if (c.st.link == ST_RUNNING) begin
      link_close = send_pkt(link_close, SND_NOTICE, ok);
    end
    link_close.lst          = push_sock(link_close.lst, SOCK_CLOSE);
    link_close.st.retry_el  = '0;
    link_close.st.retry_run = 1'b0;
    link_close.st.to_el     = '0;
    link_close.st.to_run    = 1'b0;
  endfunction

  // Restart the watchdog and the retry timer.
  function automatic ctx_t restart_both(input ctx_t c);
    restart_both              = c;
    restart_both.st.to_el     = TIMER_ONE;
    restart_both.st.to_run    = 1'b1;
    restart_both.st.retry_el  = TIMER_ONE;
    restart_both.st.retry_run = 1'b1;
  endfunction

  // Packet resent or ping sent when the retry timer expires in a state.
  function automatic logic [2:0] retry_pkt(input link_state_e s);
    unique case (s)
      ST_LOGIN:   retry_pkt = SND_LOGIN;
      ST_AUTH:    retry_pkt = SND_AUTH;
      ST_CONFIG:  retry_pkt = SND_CONFIG;
      ST_OPTIONS: retry_pkt = SND_OPTIONS;
      ST_RUNNING: retry_pkt = SND_PING;
      default:    retry_pkt = SND_NONE;
    endcase
  endfunction

endpackage

// File: sv/llkf_step.sv
// Combinational event processing: next link state and the result set of one item.
module llkf_step (
  input  llkf_pkg::in_item_t item_i,
  input  llkf_pkg::state_t   state_i,
  input  llkf_pkg::cfg_t     cfg_i,
  output llkf_pkg::state_t   state_o,
  output llkf_pkg::res_set_t res_o
);

  always_comb begin
    llkf_pkg::ctx_t c;
    logic           done;
    logic           enq;
    logic           bflag;
    logic           ok;

    c.st  = state_i;
    c.lst = '0;
    done  = 1'b0;
    enq   = 1'b0;
    ok    = item_i.send_ok;
    bflag = state_i.beacon;

    unique case (llkf_pkg::mode_e'(item_i.mode))
      llkf_pkg::MODE_STEP: begin
        if (c.st.link == llkf_pkg::ST_CONNECT) begin
          // Waiting for connect: the retry timer paces socket open attempts.
          c.st.retry_el = llkf_pkg::timer_clock(c.st.retry_el, c.st.retry_run,
                                                cfg_i.retry_period, item_i.tick_ms);
          if (llkf_pkg::timer_expired(c.st.retry_el, c.st.retry_run, cfg_i.retry_period)) begin
            c.lst = llkf_pkg::push_sock(c.lst, llkf_pkg::SOCK_OPEN);
            if (item_i.socket_open_ok) begin
              c = llkf_pkg::send_pkt(c, llkf_pkg::SND_LOGIN, ok);
              if (ok) begin
                c.st.link      = llkf_pkg::ST_LOGIN;
                c.st.to_el     = llkf_pkg::TIMER_ONE;
                c.st.to_run    = 1'b1;
                c.st.retry_el  = llkf_pkg::TIMER_ONE;
                c.st.retry_run = 1'b1;
              end
            end else begin
              c.st.retry_el  = llkf_pkg::TIMER_ONE;
              c.st.retry_run = 1'b1;
            end
          end
        end else if (item_i.read_failed) begin
          // A socket read error forces a reconnect.
          c = llkf_pkg::link_open(llkf_pkg::link_close(c, ok));
        end else begin
          // Received packet handling; only packets from the master count.
          if (item_i.packet_present && item_i.from_master) begin
            unique case (item_i.packet_kind)
              llkf_pkg::PKT_DATA: begin
                enq = cfg_i.rx_enabled;
              end
              llkf_pkg::PKT_NAK: begin
                if (c.st.link == llkf_pkg::ST_RUNNING) begin
                  c.st.link = llkf_pkg::ST_LOGIN;
                  c         = llkf_pkg::restart_both(c);
                end else begin
                  c    = llkf_pkg::link_open(llkf_pkg::link_close(c, ok));
                  done = 1'b1;
                end
              end
              llkf_pkg::PKT_ACK: begin
                unique case (c.st.link)
                  llkf_pkg::ST_LOGIN: begin
                    c.st.salt = item_i.salt_word;
                    c         = llkf_pkg::send_pkt(c, llkf_pkg::SND_AUTH, ok);
                    c.st.link = llkf_pkg::ST_AUTH;
                    c         = llkf_pkg::restart_both(c);
                  end
                  llkf_pkg::ST_AUTH: begin
                    c         = llkf_pkg::send_pkt(c, llkf_pkg::SND_CONFIG, ok);
                    c.st.link = llkf_pkg::ST_CONFIG;
                    c         = llkf_pkg::restart_both(c);
                  end
                  llkf_pkg::ST_CONFIG: begin
                    if (cfg_i.options_present) begin
                      c         = llkf_pkg::send_pkt(c, llkf_pkg::SND_OPTIONS, ok);
                      c.st.link = llkf_pkg::ST_OPTIONS;
                    end else begin
                      c.st.link = llkf_pkg::ST_RUNNING;
                    end
                    c = llkf_pkg::restart_both(c);
                  end
                  llkf_pkg::ST_OPTIONS: begin
                    c.st.link = llkf_pkg::ST_RUNNING;
                    c         = llkf_pkg::restart_both(c);
                  end
                  default: begin
                  end
                endcase
              end
              llkf_pkg::PKT_MST_CLOSE: begin
                c = llkf_pkg::link_open(llkf_pkg::link_close(c, ok));
              end
              llkf_pkg::PKT_PONG: begin
                c.st.to_el  = llkf_pkg::TIMER_ONE;
                c.st.to_run = 1'b1;
              end
              llkf_pkg::PKT_BEACON: begin
                c.st.beacon = 1'b1;
              end
              default: begin
              end
            endcase
          end

          if (!done) begin
            // Retry timer: resend the pending login packet or ping.
            c.st.retry_el = llkf_pkg::timer_clock(c.st.retry_el, c.st.retry_run,
                                                  cfg_i.retry_period, item_i.tick_ms);
            if (llkf_pkg::timer_expired(c.st.retry_el, c.st.retry_run,
                                        cfg_i.retry_period)) begin
              if (llkf_pkg::retry_pkt(c.st.link) != llkf_pkg::SND_NONE) begin
                c = llkf_pkg::send_pkt(c, llkf_pkg::retry_pkt(c.st.link), ok);
              end
              c.st.retry_el  = llkf_pkg::TIMER_ONE;
              c.st.retry_run = 1'b1;
            end

            // Watchdog: no acknowledgement in time restarts the link.
            c.st.to_el = llkf_pkg::timer_clock(c.st.to_el, c.st.to_run,
                                               cfg_i.timeout_period, item_i.tick_ms);
            if (llkf_pkg::timer_expired(c.st.to_el, c.st.to_run, cfg_i.timeout_period)) begin
              c = llkf_pkg::link_open(llkf_pkg::link_close(c, ok));
            end
          end
        end
        bflag = c.st.beacon;
      end
      llkf_pkg::MODE_OPEN: begin
        c     = llkf_pkg::link_open(c);
        bflag = c.st.beacon;
      end
      llkf_pkg::MODE_CLOSE: begin
        c     = llkf_pkg::link_close(c, ok);
        bflag = c.st.beacon;
      end
      llkf_pkg::MODE_BEACON: begin
        // Report the flag as it was, then clear it.
        bflag       = state_i.beacon;
        c.st.beacon = 1'b0;
      end
      default: begin
      end
    endcase

    // An item with no action still produces one empty result.
    if (c.lst.cnt == '0) begin
      c.lst = llkf_pkg::new_res(c.lst, llkf_pkg::SND_NONE, llkf_pkg::SOCK_NONE);
    end

    state_o     = c.st;
    res_o.lst   = c.lst;
    res_o.enq   = enq;
    res_o.bflag = bflag;
    res_o.link  = c.st.link;
    res_o.salt  = c.st.salt;
  end

endmodule

// File: sv/llkf_res_buf.sv
// Result register that holds one item's result set and hands it out one transfer at a time.
module llkf_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  llkf_pkg::res_set_t  res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output llkf_pkg::out_item_t out_item_o
);

  logic                       valid_q;
  logic [llkf_pkg::CNT_W-1:0] idx_q;
  llkf_pkg::res_set_t         res_q;
  logic                       take;
  logic                       is_last;

  // Output transfer bookkeeping.
  assign is_last     = (idx_q == (res_q.lst.cnt - llkf_pkg::CNT_W'(1)));
  assign out_valid_o = valid_q;
  assign take        = valid_q && !out_stall_i;
  assign free_o      = !valid_q || (take && is_last);

  // Current result item.
  always_comb begin
    out_item_o.send_kind     = res_q.lst.snd[idx_q];
    out_item_o.socket_action = res_q.lst.sck[idx_q];
    out_item_o.enqueue_data  = res_q.enq;
    out_item_o.beacon_flag   = res_q.bflag;
    out_item_o.link_state    = res_q.link;
    out_item_o.auth_salt     = res_q.salt;
    out_item_o.last          = is_last;
  end

  // Control: load a new set, step through it, empty after the last transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take && is_last) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + llkf_pkg::CNT_W'(1);
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: sv/link_login_keepalive_fsm_core.sv
// Top level of the link login and keepalive controller: input register, state, configuration.
// Each event enters an input register, is processed combinationally against the link state
// and lands in a result register. An event that yields one result sustains one event per
// clock while the output does not stall; an event that yields n results (at most three)
// holds the result register for n output transfers, and the input register accepts the next
// event while those wait. Configuration writes are always ready and must only be issued while
// the block is idle.
module link_login_keepalive_fsm_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  llkf_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output llkf_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [llkf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [llkf_pkg::PERIOD_W-1:0]  cfg_data_i
);

  logic               s1_valid_q;
  llkf_pkg::in_item_t s1_item_q;
  llkf_pkg::state_t   state_q;
  llkf_pkg::state_t   state_d;
  llkf_pkg::cfg_t     cfg_q;
  llkf_pkg::res_set_t res_set;
  logic               buf_free;
  logic               s2_load;
  logic               in_take;

  // Input handshake: the input register moves on when the result register can load.
  assign s2_load     = s1_valid_q && buf_free;
  assign in_stall_o  = s1_valid_q && !buf_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s2_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
  end

  // Event processing.
  llkf_step u_step (
    .item_i  (s1_item_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res_o   (res_set)
  );

  // Link state is committed when the event moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.link      <= llkf_pkg::ST_CONNECT;
      state_q.retry_el  <= '0;
      state_q.retry_run <= 1'b0;
      state_q.to_el     <= '0;
      state_q.to_run    <= 1'b0;
      state_q.beacon    <= 1'b0;
      state_q.salt      <= '0;
    end else if (s2_load) begin
      state_q <= state_d;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rx_enabled      <= 1'b0;
      cfg_q.options_present <= 1'b0;
      cfg_q.retry_period    <= llkf_pkg::RETRY_PERIOD_RST;
      cfg_q.timeout_period  <= llkf_pkg::TIMEOUT_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (llkf_pkg::cfg_idx_e'(cfg_index_i))
        llkf_pkg::CFG_RX_ENABLED:      cfg_q.rx_enabled      <= cfg_data_i[0];
        llkf_pkg::CFG_OPTIONS_PRESENT: cfg_q.options_present <= cfg_data_i[0];
        llkf_pkg::CFG_RETRY_PERIOD:    cfg_q.retry_period    <= cfg_data_i;
        llkf_pkg::CFG_TIMEOUT_PERIOD:  cfg_q.timeout_period  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Result register and output sequencing.
  llkf_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s2_load),
    .res_i       (res_set),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
